/* design/assert_macros.svh */
// Assertion macros for the flicker brightness RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an invariant at every clock edge outside reset
`define CFB_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
    else $error("invariant violated");

// Check a consequence in the cycle after a condition
`define CFB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("next-cycle check violated");

`endif

/* design/cfb_pkg.sv */
// Types, constants and control program of the flicker brightness unit
`default_nettype none

package cfb_pkg;

  localparam int NUDGE_W = 10;
  localparam int SPEED_W = 4;
  localparam int DUTY_W  = 8;
  localparam int REG_W   = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SPAN_W  = 4;
  localparam int DEN_W   = 14;
  localparam int STEP_W  = 4;

  localparam logic [REG_W-1:0]   DUTY_OFFSET_RST = 8'd160;
  localparam logic [REG_W-1:0]   DUTY_GAIN_RST   = 8'd96;
  localparam logic [SPAN_W-1:0]  SPAN_RST  = 4'd4;
  localparam logic [SPAN_W-1:0]  SPAN_BASE = 4'd3;
  localparam logic [SPAN_W-1:0]  SPAN_MAX  = 4'd11;
  localparam logic [NUDGE_W-1:0] NUDGE_MOD = 10'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MOD = 4'd9;
  localparam logic [DEN_W-1:0]   NUDGE_DEN = 14'd10000;
  localparam int                 NUDGE_ROUND = 5000;

  localparam logic REG_DUTY_OFFSET = 1'b0;
  localparam logic REG_DUTY_GAIN   = 1'b1;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SQUARE    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAP       = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CHAOS     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SPAN_MUL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SMOOTH_LD = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SMOOTH_DV = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SMOOTH_WR = 4'd7;
  localparam logic [STEP_W-1:0] STEP_GAIN_MUL  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd9;

  typedef enum logic [1:0] {MUL_NONE, MUL_SQUARE, MUL_SPAN, MUL_GAIN} cfb_mul_t;
  typedef enum logic [1:0] {DIV_NONE, DIV_NUDGE, DIV_SMOOTH} cfb_div_t;
  typedef enum logic [2:0] {WR_NONE, WR_MAP, WR_CHAOS, WR_SMOOTH, WR_OUT} cfb_wr_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_ACCEPT, JMP_DIV, JMP_OUT} cfb_jmp_t;

  typedef struct packed {
    cfb_mul_t          mul;
    cfb_div_t          div_ld;
    logic              div_step;
    cfb_wr_t           wr;
    cfb_jmp_t          jmp;
    logic [STEP_W-1:0] target;
  } cfb_ctrl_t;

  function automatic cfb_ctrl_t cfb_rom(input logic [STEP_W-1:0] step);
    cfb_ctrl_t cw;
    cw = '{mul: MUL_NONE, div_ld: DIV_NONE, div_step: 1'b0, wr: WR_NONE,
           jmp: JMP_NEXT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        cw.jmp = JMP_ACCEPT;
        cw.target = STEP_SPAN_MUL;
      end
      STEP_SQUARE:    cw.mul = MUL_SQUARE;
      STEP_MAP: begin
        cw.wr = WR_MAP;
        cw.div_ld = DIV_NUDGE;
      end
      STEP_CHAOS:     cw.wr = WR_CHAOS;
      STEP_SPAN_MUL:  cw.mul = MUL_SPAN;
      STEP_SMOOTH_LD: cw.div_ld = DIV_SMOOTH;
      STEP_SMOOTH_DV: begin
        cw.div_step = 1'b1;
        cw.jmp = JMP_DIV;
      end
      STEP_SMOOTH_WR: cw.wr = WR_SMOOTH;
      STEP_GAIN_MUL:  cw.mul = MUL_GAIN;
      STEP_EMIT: begin
        cw.wr = WR_OUT;
        cw.jmp = JMP_OUT;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.jmp = JMP_OUT;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

/* design/cfb_if.sv */
// Valid/ready channel interfaces for tick input and duty output
`default_nettype none

interface cfb_in_if import cfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NUDGE_W-1:0] nudge_random;
  logic [SPEED_W-1:0] speed_random;

  modport source (output valid, output nudge_random, output speed_random, input ready);
  modport sink   (input valid, input nudge_random, input speed_random, output ready);
endinterface

interface cfb_out_if import cfb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;

  modport source (output valid, output pwm_duty, input ready);
  modport sink   (input valid, input pwm_duty, output ready);
endinterface

`default_nettype wire

/* design/chaotic_flicker_brightness_unit.sv */
// Candle-flicker brightness generator: microcoded chaos map, smoothing and duty scaling
// Each accepted tick runs square, map and chaos steps when the chaos map runs (skipped
// otherwise), then span multiply, smoothing divide, gain multiply and emit; the restoring
// division of the smoothing step runs through the bit-serial divider.
// A new tick is accepted only after the previous duty has been emitted.
// Reset: synchronous active low; restores config registers, chaos, smoothing, span and step state, empties the output.
`default_nettype none

module chaotic_flicker_brightness_unit import cfb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cfb_in_if.sink                     in_chan,
  cfb_out_if.source                  out_chan,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

`include "assert_macros.svh"

  localparam int W      = FRAC_BITS + 1;
  localparam int PW     = 2 * W;
  localparam int DW     = FRAC_BITS + 10;
  localparam int CNT_W  = $clog2(W);
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam logic [W-1:0] ONE  = W'(ONE_I);
  localparam logic [W-1:0] HALF = W'(ONE_I / 2);
  localparam logic [W-1:0] LOW  = W'((5 * ONE_I + 500) / 1000);
  localparam logic [W-1:0] HIGH = ONE - LOW;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(W - 1);

  // scale numerator and divisor down by 16, then divide by reciprocal multiplication
  localparam int NUDGE_SH      = 4;
  localparam int NUDGE_DIVISOR = int'(NUDGE_DEN) >> NUDGE_SH;
  localparam int NUDGE_BIAS    = NUDGE_ROUND >> NUDGE_SH;
  localparam int NUM_W         = NUDGE_W + FRAC_BITS - NUDGE_SH;
  localparam int RC_W          = FRAC_BITS + 7;
  localparam int NUDGE_K       = FRAC_BITS + 16;
  localparam int NP_W          = NUM_W + RC_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << NUDGE_K) + 64'(NUDGE_DIVISOR) - 64'd1) / 64'(NUDGE_DIVISOR);
  localparam logic [RC_W-1:0] NUDGE_RECIP = RC_W'(RECIP_L);

  logic [STEP_W-1:0]  pc_r, pc_nxt;
  cfb_ctrl_t          cw;
  logic [REG_W-1:0]   offset_r, gain_r;
  logic [W-1:0]       chaos_r, chaos_nxt;
  logic [W-1:0]       smooth_r;
  logic [SPAN_W-1:0]  step_cnt_r, span_r, span_eff, cnt_inc;
  logic [NUDGE_W-1:0] nudge_r, nudge_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [W-1:0]       map_r, map_nxt, map_term, mul_a, mul_b, sq_op;
  logic [W:0]         nudge_sum;
  logic [NUM_W-1:0]   nudge_num;
  logic [NP_W-1:0]    nudge_prod_r;
  logic [W-1:0]       nudge_val;
  logic [PW-1:0]      prod_r;
  logic [DW-1:0]      div_load;
  logic [DEN_W-1:0]   div_rem_r, div_rem_nxt, div_den_r;
  logic [DEN_W:0]     div_trial;
  logic [W-1:0]       div_num_r;
  logic               div_ge;
  logic [CNT_W-1:0]   div_cnt_r;
  logic               out_valid_r, out_free, emit_en, in_accept, cfg_wr;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [DUTY_W:0]    duty_sum;

  assign cw        = cfb_rom(pc_r);
  assign in_chan.ready = (cw.jmp == JMP_ACCEPT);
  assign in_accept = in_chan.valid & in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign emit_en   = (cw.wr == WR_OUT) && out_free;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.pwm_duty = duty_r;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = CFG_DATA_W'((paddr[2] == REG_DUTY_GAIN) ? gain_r : offset_r);

  always_comb begin
    nudge_nxt = (in_chan.nudge_random >= NUDGE_MOD) ?
                in_chan.nudge_random - NUDGE_MOD : in_chan.nudge_random;
    speed_nxt = (in_chan.speed_random >= SPEED_MOD) ?
                in_chan.speed_random - SPEED_MOD : in_chan.speed_random;
    span_eff  = (span_r == '0) ? SPAN_W'(1) : span_r;
    sq_op     = (chaos_r < HALF) ? chaos_r : ONE - chaos_r;

    case (cw.mul)
      MUL_SQUARE: begin
        mul_a = sq_op;
        mul_b = sq_op;
      end
      MUL_SPAN: begin
        mul_a = smooth_r;
        mul_b = W'(span_eff - SPAN_W'(1));
      end
      MUL_GAIN: begin
        mul_a = smooth_r;
        mul_b = W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    map_term = prod_r[FRAC_BITS-1 +: W];
    if (chaos_r < HALF) begin
      map_nxt = chaos_r + map_term;
    end else begin
      map_nxt = (map_term > chaos_r) ? '0 : chaos_r - map_term;
    end

    nudge_num = {nudge_r, {(FRAC_BITS - NUDGE_SH){1'b0}}} + NUM_W'(NUDGE_BIAS);
    nudge_val = W'(nudge_prod_r[NP_W-1:NUDGE_K]);

    nudge_sum = {1'b0, map_r} + {1'b0, nudge_val};
    if (map_r < LOW) begin
      chaos_nxt = (nudge_sum > {1'b0, ONE}) ? ONE : nudge_sum[W-1:0];
    end else if (map_r > HIGH) begin
      chaos_nxt = (nudge_val > map_r) ? '0 : map_r - nudge_val;
    end else begin
      chaos_nxt = map_r;
    end

    case (cw.div_ld)
      DIV_SMOOTH: div_load = prod_r[DW-1:0] + DW'(chaos_r);
      default:    div_load = '0;
    endcase

    div_trial   = {div_rem_r, div_num_r[W-1]};
    div_ge      = div_trial >= {1'b0, div_den_r};
    div_rem_nxt = div_ge ? DEN_W'(div_trial - {1'b0, div_den_r}) : div_trial[DEN_W-1:0];

    duty_sum = {1'b0, prod_r[FRAC_BITS +: DUTY_W]} + {1'b0, offset_r};
    duty_nxt = duty_sum[DUTY_W] ? '1 : duty_sum[DUTY_W-1:0];
    cnt_inc  = step_cnt_r + SPAN_W'(1);

    case (cw.jmp)
      JMP_NEXT:   pc_nxt = pc_r + STEP_W'(1);
      JMP_ACCEPT: begin
        if (!in_accept) begin
          pc_nxt = pc_r;
        end else if (step_cnt_r == '0) begin
          pc_nxt = STEP_SQUARE;
        end else begin
          pc_nxt = cw.target;
        end
      end
      JMP_DIV:    pc_nxt = (div_cnt_r == DIV_LAST) ? pc_r + STEP_W'(1) : pc_r;
      JMP_OUT:    pc_nxt = out_free ? cw.target : pc_r;
      default:    pc_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      out_valid_r <= 1'b0;
      offset_r    <= DUTY_OFFSET_RST;
      gain_r      <= DUTY_GAIN_RST;
      chaos_r     <= HALF;
      smooth_r    <= HALF;
      step_cnt_r  <= '0;
      span_r      <= SPAN_RST;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_DUTY_GAIN) begin
          gain_r <= pwdata[REG_W-1:0];
        end else begin
          offset_r <= pwdata[REG_W-1:0];
        end
      end
      if (cw.wr == WR_CHAOS) begin
        chaos_r <= chaos_nxt;
      end
      if (cw.wr == WR_SMOOTH) begin
        smooth_r <= div_num_r;
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
        if (cnt_inc > span_r) begin
          step_cnt_r <= '0;
          span_r     <= SPAN_W'(speed_r) + SPAN_BASE;
        end else begin
          step_cnt_r <= cnt_inc;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      nudge_r <= nudge_nxt;
      speed_r <= speed_nxt;
    end
    if (cw.mul != MUL_NONE) begin
      prod_r <= PW'(mul_a * mul_b);
    end
    if (cw.wr == WR_MAP) begin
      map_r <= map_nxt;
    end
    if (cw.div_ld == DIV_NUDGE) begin
      nudge_prod_r <= NP_W'(nudge_num * NUDGE_RECIP);
    end
    if (cw.div_ld == DIV_SMOOTH) begin
      div_rem_r <= DEN_W'(div_load[DW-1:W]);
      div_num_r <= div_load[W-1:0];
      div_den_r <= DEN_W'(span_eff);
      div_cnt_r <= '0;
    end else if (cw.div_step) begin
      div_rem_r <= div_rem_nxt;
      div_num_r <= {div_num_r[W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
    if (emit_en) begin
      duty_r <= duty_nxt;
    end
  end

  `CFB_ASSERT_ALWAYS(a_chaos_bound, clk, rst_n, chaos_r <= ONE && smooth_r <= ONE)
  `CFB_ASSERT_ALWAYS(a_span_range, clk, rst_n, span_r >= SPAN_BASE && span_r <= SPAN_MAX)
  `CFB_ASSERT_ALWAYS(a_count_bound, clk, rst_n, step_cnt_r <= span_r)
  `CFB_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit_en, out_chan.valid && in_chan.ready)

endmodule

`default_nettype wire

/* tb/sv/cfb_tb_pkg.sv */
// Register map shared by the flicker brightness testbench modules
package cfb_tb_pkg;
  import cfb_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_DUTY_OFFSET = {REG_DUTY_OFFSET, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_DUTY_GAIN   = {REG_DUTY_GAIN, 2'b00};
endpackage

/* tb/sv/cfb_duty_checker.sv */
// Duty predictor and scoreboard watching the tick, duty and register ports
module cfb_duty_checker import cfb_pkg::*, cfb_tb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [NUDGE_W-1:0]    in_nudge,
  input  logic [SPEED_W-1:0]    in_speed,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DUTY_W-1:0]     out_duty,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  output int                    mismatches,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              FX_FRAC    = 16;
  localparam longint unsigned FX_UNIT    = 64'd1 << FX_FRAC;
  localparam longint unsigned FX_MID     = FX_UNIT >> 1;
  localparam longint unsigned FX_NEAR_LO = (5 * FX_UNIT + 500) / 1000;
  localparam longint unsigned FX_NEAR_HI = FX_UNIT - FX_NEAR_LO;
  localparam longint unsigned DUTY_MAX   = (64'd1 << DUTY_W) - 1;

  logic [REG_W-1:0]   offset_reg;
  logic [REG_W-1:0]   gain_reg;
  logic [FX_FRAC:0]   chaos_x;
  logic [FX_FRAC:0]   glow_y;
  logic [SPAN_W-1:0]  tick_count;
  logic [SPAN_W-1:0]  span_len;
  logic [DUTY_W-1:0]  duty_expect_q[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DUTY_W-1:0] flicker_tick(input logic [NUDGE_W-1:0] nudge_raw,
                                                     input logic [SPEED_W-1:0] speed_raw);
    longint unsigned r, s, x, d, t, push, span, y, duty;
    r = nudge_raw % NUDGE_MOD;
    s = speed_raw % SPEED_MOD;
    x = chaos_x;
    if (tick_count == '0) begin
      if (x < FX_MID) begin
        x = x + ((2 * x * x) >> FX_FRAC);
      end else begin
        d = (x >= FX_UNIT) ? 0 : FX_UNIT - x;
        t = (2 * d * d) >> FX_FRAC;
        x = (t > x) ? 0 : x - t;
      end
      // push back from the ends of the unit interval
      push = (r * FX_UNIT + NUDGE_ROUND) / NUDGE_DEN;
      if (x < FX_NEAR_LO) begin
        x = x + push;
      end else if (x > FX_NEAR_HI) begin
        x = (push > x) ? 0 : x - push;
      end
      if (x > FX_UNIT) x = FX_UNIT;
      chaos_x = x[FX_FRAC:0];
    end
    span = (span_len == '0) ? 1 : span_len;
    y = glow_y;
    y = (y * (span - 1) + x) / span;
    glow_y = y[FX_FRAC:0];
    duty = ((y * gain_reg) >> FX_FRAC) + offset_reg;
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    tick_count = tick_count + 1'b1;
    if (tick_count > span_len) begin
      tick_count = '0;
      span_len = s[SPAN_W-1:0] + SPAN_BASE;
    end
    return duty[DUTY_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [DUTY_W-1:0]     want;
    logic [CFG_DATA_W-1:0] reg_word;
    if (!rst_n) begin
      offset_reg = DUTY_OFFSET_RST;
      gain_reg   = DUTY_GAIN_RST;
      chaos_x    = FX_MID;
      glow_y     = FX_MID;
      tick_count = '0;
      span_len   = SPAN_RST;
      duty_expect_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            ADDR_DUTY_OFFSET: offset_reg = pwdata[REG_W-1:0];
            ADDR_DUTY_GAIN:   gain_reg = pwdata[REG_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr)
            ADDR_DUTY_OFFSET: begin
              reg_word = CFG_DATA_W'(offset_reg);
              if (prdata !== reg_word) report("duty_offset readback", prdata, reg_word);
            end
            ADDR_DUTY_GAIN: begin
              reg_word = CFG_DATA_W'(gain_reg);
              if (prdata !== reg_word) report("duty_gain readback", prdata, reg_word);
            end
            default: ;
          endcase
        end
      end
      if (in_valid && in_ready) duty_expect_q.push_back(flicker_tick(in_nudge, in_speed));
      if (out_valid && out_ready) begin
        if (duty_expect_q.size() == 0) begin
          report("duty transaction with no tick pending", out_duty, 0);
        end else begin
          want = duty_expect_q.pop_front();
          if (out_duty !== want) report("pwm_duty", out_duty, want);
        end
      end
    end
    pending = duty_expect_q.size();
  end
endmodule

/* tb/sv/tb_top.sv */
// Top of the flicker brightness testbench: clock, reset, stimulus and verdict
module tb_top import cfb_pkg::*, cfb_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_SLACK      = 60;
  localparam int PHASE_TICKS    = 280;
  localparam int DIRECTED_TICKS = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cfb_in_if  in_ch ();
  cfb_out_if out_ch ();

  int mismatches;
  int pending;
  int ticks_sent;
  int settings_used;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_off_req;

  logic [NUDGE_W-1:0] dir_nudge [DIRECTED_TICKS] = '{
    0, 999, 1000, 1023, 1, 998, 500, 512, 341, 682,
    0, 1023, 999, 1000, 5, 250, 750, 1010, 0, 999};
  logic [SPEED_W-1:0] dir_speed [DIRECTED_TICKS] = '{
    0, 8, 9, 15, 1, 2, 3, 4, 5, 6,
    7, 10, 11, 12, 13, 14, 15, 0, 8, 9};

  chaotic_flicker_brightness_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cfb_duty_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_nudge   (in_ch.nudge_random),
    .in_speed   (in_ch.speed_random),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_duty   (out_ch.pwm_duty),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_tick(input logic [NUDGE_W-1:0] n, input logic [SPEED_W-1:0] s);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.nudge_random <= n;
    in_ch.speed_random <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [REG_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[REG_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [REG_W-1:0] offset, input logic [REG_W-1:0] gain,
                           input int count, input bit hold, input bit pause, input bit quiet);
    logic [NUDGE_W-1:0] n;
    logic [SPEED_W-1:0] s;
    wait_drain();
    cfg_access(1'b1, ADDR_DUTY_OFFSET, offset);
    cfg_access(1'b1, ADDR_DUTY_GAIN, gain);
    cfg_access(1'b0, ADDR_DUTY_OFFSET, '0);
    cfg_access(1'b0, ADDR_DUTY_GAIN, '0);
    settings_used++;
    if (hold) hold_off_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      tx_idle_en = !quiet && ((i / 40) % 3 != 2);
      rx_idle_en = tx_idle_en;
      if (pause && i == count / 2) wait_drain();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       n = 0;
          1:       n = 999;
          2:       n = 1000;
          default: n = 1023;
        endcase
      end else begin
        n = $urandom_range(0, 1023);
      end
      s = $urandom_range(0, 15);
      send_tick(n, s);
    end
  endtask

  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a transaction, %0d duties pending", quiet, pending);
    $display("chaotic_flicker_brightness_unit test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.nudge_random = '0;
    in_ch.speed_random = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tx_idle_en         = 1'b1;
    rx_idle_en         = 1'b1;
    hold_off_req       = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_access(1'b0, ADDR_DUTY_OFFSET, '0);
    cfg_access(1'b0, ADDR_DUTY_GAIN, '0);
    for (int i = 0; i < DIRECTED_TICKS; i++) send_tick(dir_nudge[i], dir_speed[i]);

    run_phase(8'd255, 8'd255, PHASE_TICKS, 1'b1, 1'b0, 1'b0);
    run_phase(8'd0, 8'd0, PHASE_TICKS, 1'b0, 1'b1, 1'b0);
    run_phase(8'd255, 8'd0, PHASE_TICKS, 1'b0, 1'b0, 1'b0);
    run_phase(8'd0, 8'd255, PHASE_TICKS, 1'b0, 1'b0, 1'b0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), PHASE_TICKS, 1'b0, 1'b0, 1'b0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), PHASE_TICKS, 1'b0, 1'b0, 1'b1);

    wait_drain();
    repeat (END_SLACK) @(posedge clk);
    $display("Ran %0d ticks over %0d duty settings plus reset values,", ticks_sent,
             settings_used);
    $display("with a %0d-cycle output hold, a full drain mid-stream and register readbacks.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("chaotic_flicker_brightness_unit test passed");
    end else begin
      $display("chaotic_flicker_brightness_unit test failed");
    end
    $finish;
  end
endmodule
